// ===== hdl/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

   localparam int CH_W      = 8;
   localparam int HUE_IN_W  = 16;
   localparam int HUE_OUT_W = 9;

   // Degrees, full scale and the fixed denominator of q and t
   localparam int DEG_FULL   = 360;
   localparam int DEG_SECTOR = 60;
   localparam int SV_FULL    = 255;
   localparam int QT_DEN     = DEG_SECTOR * SV_FULL;

   // hue / 360 as (hue * HUE_RECIP) >> HUE_RECIP_SHIFT, exact for 16-bit hue
   localparam int HUE_RECIP       = 46604;
   localparam int HUE_RECIP_SHIFT = 24;
   localparam int HUE_QUO_W       = 8;

   // x / 15300 as (x * QT_RECIP) >> QT_SHIFT, low by at most one
   localparam int QT_RECIP = 70179;
   localparam int QT_SHIFT = 30;
   localparam int QT_NUM_W = 22;
   localparam int QT_PRD_W = 39;

   // Register stages from the input beat to the result register
   localparam int PIPE_DEPTH = 7;

   // Restoring divider parameters, used by both the hue and the saturation divider
   localparam int DIV_NUM_W  = 17;
   localparam int DIV_DEN_W  = 8;
   localparam int DIV_QUO_W  = 9;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (DIV_QUO_W + DIV_STEPS - 1) / DIV_STEPS;

   // Which channel holds the maximum
   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

   typedef struct packed {
      logic                action;
      logic [HUE_IN_W-1:0] hue_in;
      logic [CH_W-1:0]     sat_in;
      logic [CH_W-1:0]     val_in;
      logic [CH_W-1:0]     red_in;
      logic [CH_W-1:0]     green_in;
      logic [CH_W-1:0]     blue_in;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]      red_out;
      logic [CH_W-1:0]      green_out;
      logic [CH_W-1:0]      blue_out;
      logic [HUE_OUT_W-1:0] hue_out;
      logic [CH_W-1:0]      sat_out;
      logic [CH_W-1:0]      val_out;
   } rsp_type;

   typedef struct packed {
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_in_type;

endpackage

// ===== hdl/hsvrgb_if.sv =====
interface hsvrgb_req_if import hsvrgb_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hsvrgb_rsp_if import hsvrgb_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/hsvrgb_div.sv =====
module hsvrgb_div import hsvrgb_pkg::*; (
   input  logic                 clock,
   input  logic                 advance,
   input  div_in_type           div_in,
   output logic [DIV_QUO_W-1:0] quo
);

   logic [DIV_NUM_W-1:0] rem_src [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_src [DIV_STAGES];
   logic [DIV_QUO_W-1:0] quo_src [DIV_STAGES];

   logic [DIV_NUM_W-1:0] rem_in [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_in [DIV_STAGES];
   logic [DIV_QUO_W-1:0] quo_in [DIV_STAGES];

   logic [DIV_NUM_W-1:0] rem_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_ff [DIV_STAGES];
   logic [DIV_QUO_W-1:0] quo_ff [DIV_STAGES];

   always_comb begin
      rem_src[0] = div_in.num;
      den_src[0] = div_in.den;
      quo_src[0] = '0;
      for (int st = 1; st < DIV_STAGES; st++) begin
         rem_src[st] = rem_ff[st-1];
         den_src[st] = den_ff[st-1];
         quo_src[st] = quo_ff[st-1];
      end
   end

   // Two quotient bits per stage, most significant first
   always_comb begin
      logic [DIV_NUM_W-1:0] rem_w;
      logic [DIV_QUO_W-1:0] quo_w;
      logic [DIV_NUM_W-1:0] trial;
      int                   bit_idx;
      for (int st = 0; st < DIV_STAGES; st++) begin
         rem_w = rem_src[st];
         quo_w = quo_src[st];
         for (int k = 0; k < DIV_STEPS; k++) begin
            bit_idx = DIV_QUO_W - 1 - DIV_STEPS * st - k;
            trial   = '0;
            if (bit_idx >= 0) begin
               trial = DIV_NUM_W'(den_src[st]) << bit_idx;
               if (rem_w >= trial) begin
                  rem_w          = rem_w - trial;
                  quo_w[bit_idx] = 1'b1;
               end
            end
         end
         rem_in[st] = rem_w;
         den_in[st] = den_src[st];
         quo_in[st] = quo_w;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int st = 0; st < DIV_STAGES; st++) begin
            rem_ff[st] <= rem_in[st];
            den_ff[st] <= den_in[st];
            quo_ff[st] <= quo_in[st];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

// ===== hdl/hsv_rgb_color_converter_core.sv =====
// HSV / RGB color converter, one pixel per beat.
//
// req_chan carries one pixel and an action bit: action 0 turns hue (any
// 16-bit degree count, taken modulo 360), saturation and value into red,
// green and blue; action 1 turns red, green and blue into hue (0..359),
// saturation and value. Saturation and value use 0..255 for 0..1. Each
// request beat yields exactly one rsp_chan beat, in order; the fields of
// the direction not asked for read as zero.
//
// An accepted beat runs through the pipeline into the result register,
// which drives rsp_chan. One beat per cycle while req_chan.ready is high;
// seven register stages (hue reduction, sector split, products, reciprocal
// multiply and correction, plus a five-stage radix-4 divider for hue and
// saturation) all hold a beat at once.
//
// When the receiver stalls, the result register holds its beat and a
// skid register catches the next one; only while the skid register is
// full does the whole pipeline freeze and req_chan.ready drop.
// Reset (synchronous) clears all valid bits: nothing is in flight after.
module hsv_rgb_color_converter_core import hsvrgb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   hsvrgb_req_if.sink   req_chan,
   hsvrgb_rsp_if.source rsp_chan
);

   req_type pl;
   logic    advance;
   logic    req_accept;
   logic    rsp_take;
   logic    res_arrive;

   // Valid bits and side data that ride along the pipeline
   logic [PIPE_DEPTH:1] vld_ff;
   logic                act_ff [1:PIPE_DEPTH];
   logic [CH_W-1:0]     mx_ff  [1:PIPE_DEPTH];
   logic [CH_W-1:0]     sat_ff [1:PIPE_DEPTH-1];
   logic [CH_W-1:0]     val_ff [1:PIPE_DEPTH-1];

   // Stage 1
   logic [31:0]       hprod_in, hprod_ff;
   logic [HUE_IN_W-1:0] hue_ff;
   logic [CH_W-1:0]   mx_in, mn_s;
   logic [CH_W-1:0]   delta_in, delta_ff;
   logic [1:0]        sel_in, sel_ff;
   logic signed [8:0] diff_in, diff_ff;

   // Stage 2
   logic [HUE_QUO_W-1:0]  hq_s;
   logic [HUE_OUT_W-1:0]  h_in, h_ff;
   logic [HUE_OUT_W-1:0]  base_s;
   logic [DIV_NUM_W-1:0]  base_term_s;
   logic signed [18:0]    hnum_s;
   div_in_type            div_h_in, div_h_ff;
   div_in_type            div_s_in, div_s_ff;

   // Stage 3
   logic [2:0] sector_in;
   logic [2:0] sector_ff [3:PIPE_DEPTH-1];
   logic [5:0] f_in, f_ff;

   // Stage 4
   logic [13:0] sf_in, sf_ff;
   logic [13:0] sg_in, sg_ff;
   logic [15:0] pn_in, pn_ff;

   // Stage 5
   logic [QT_NUM_W-1:0] qn_in, tn_in;
   logic [QT_NUM_W-1:0] qn_ff [5:PIPE_DEPTH-1];
   logic [QT_NUM_W-1:0] tn_ff [5:PIPE_DEPTH-1];
   logic [CH_W-1:0]     p0_s;
   logic [15:0]         prem_s;
   logic [CH_W-1:0]     p_in;
   logic [CH_W-1:0]     p_ff [5:PIPE_DEPTH-1];

   // Stage 6
   logic [QT_PRD_W-1:0] qa_in, qa_ff;
   logic [QT_PRD_W-1:0] ta_in, ta_ff;

   // Stage 7
   logic [CH_W-1:0]     q0_s, t0_s;
   logic [QT_NUM_W-1:0] qrem_s, trem_s;
   logic [CH_W-1:0]     q_s, t_s;
   logic [CH_W-1:0]     red_in, green_in, blue_in;
   logic [CH_W-1:0]     red_ff, green_ff, blue_ff;
   logic [DIV_QUO_W-1:0] hue_quo, sat_quo;

   // Output side
   rsp_type res;
   rsp_type out_ff, skid_ff;
   logic    out_vld_in, out_vld_ff;
   logic    skid_vld_in, skid_vld_ff;
   logic    out_load_res, out_load_skid, skid_load;

   assign pl         = req_chan.payload;
   assign advance    = !skid_vld_ff;
   assign req_accept = req_chan.valid && advance;
   assign res_arrive = advance && vld_ff[PIPE_DEPTH];
   assign rsp_take   = out_vld_ff && rsp_chan.ready;

   assign req_chan.ready   = advance;
   assign rsp_chan.valid   = out_vld_ff;
   assign rsp_chan.payload = out_ff;

   // Stage 1: hue reciprocal product, channel max / min and signed difference.
   // Ties go to red, then green.
   always_comb begin
      hprod_in = 32'(pl.hue_in) * 32'(HUE_RECIP);

      mn_s = pl.red_in;
      if (pl.green_in < mn_s) mn_s = pl.green_in;
      if (pl.blue_in < mn_s) mn_s = pl.blue_in;

      if (pl.red_in >= pl.green_in && pl.red_in >= pl.blue_in) begin
         mx_in   = pl.red_in;
         sel_in  = SEL_RED;
         diff_in = signed'({1'b0, pl.green_in}) - signed'({1'b0, pl.blue_in});
      end else if (pl.green_in >= pl.blue_in) begin
         mx_in   = pl.green_in;
         sel_in  = SEL_GREEN;
         diff_in = signed'({1'b0, pl.blue_in}) - signed'({1'b0, pl.red_in});
      end else begin
         mx_in   = pl.blue_in;
         sel_in  = SEL_BLUE;
         diff_in = signed'({1'b0, pl.red_in}) - signed'({1'b0, pl.green_in});
      end
      delta_in = mx_in - mn_s;
   end

   // Stage 2: hue mod 360; numerators and divisors for hue and saturation.
   // A zero divisor only comes with a zero numerator, so force it to one.
   always_comb begin
      hq_s = hprod_ff[HUE_RECIP_SHIFT +: HUE_QUO_W];
      h_in = HUE_OUT_W'(17'(hue_ff) - 17'(hq_s) * 17'(DEG_FULL));

      case (sel_ff)
         SEL_RED:   base_s = (diff_ff < 0) ? HUE_OUT_W'(DEG_FULL) : '0;
         SEL_GREEN: base_s = HUE_OUT_W'(2 * DEG_SECTOR);
         default:   base_s = HUE_OUT_W'(4 * DEG_SECTOR);
      endcase
      base_term_s = 17'(base_s) * 17'(delta_ff);
      hnum_s      = signed'({2'b00, base_term_s}) + 19'(diff_ff) * 19'(DEG_SECTOR);

      div_h_in.num = hnum_s[DIV_NUM_W-1:0];
      div_h_in.den = (delta_ff == '0) ? 8'd1 : delta_ff;
      div_s_in.num = 17'(delta_ff) * 17'(SV_FULL);
      div_s_in.den = (mx_ff[1] == '0) ? 8'd1 : mx_ff[1];
   end

   hsvrgb_div u_hue_div (
      .clock   (clock),
      .advance (advance),
      .div_in  (div_h_ff),
      .quo     (hue_quo)
   );

   hsvrgb_div u_sat_div (
      .clock   (clock),
      .advance (advance),
      .div_in  (div_s_ff),
      .quo     (sat_quo)
   );

   // Stage 3: split the reduced hue into sector and offset
   always_comb begin
      if (h_ff < 9'(DEG_SECTOR))          sector_in = 3'd0;
      else if (h_ff < 9'(2 * DEG_SECTOR)) sector_in = 3'd1;
      else if (h_ff < 9'(3 * DEG_SECTOR)) sector_in = 3'd2;
      else if (h_ff < 9'(4 * DEG_SECTOR)) sector_in = 3'd3;
      else if (h_ff < 9'(5 * DEG_SECTOR)) sector_in = 3'd4;
      else                                sector_in = 3'd5;
      f_in = 6'(h_ff - 9'(sector_in) * 9'(DEG_SECTOR));
   end

   // Stage 4: saturation products
   always_comb begin
      sf_in = 14'(sat_ff[3]) * 14'(f_ff);
      sg_in = 14'(sat_ff[3]) * 14'(6'(DEG_SECTOR) - f_ff);
      pn_in = 16'(val_ff[3]) * 16'(8'(SV_FULL) - sat_ff[3]);
   end

   // Stage 5: q and t numerators; p = pn / 255 from pn >> 8 and one correction
   always_comb begin
      qn_in  = 22'(val_ff[4]) * 22'(14'(QT_DEN) - sf_ff);
      tn_in  = 22'(val_ff[4]) * 22'(14'(QT_DEN) - sg_ff);
      p0_s   = pn_ff[15:8];
      prem_s = pn_ff - 16'(p0_s) * 16'(SV_FULL);
      p_in   = (prem_s >= 16'(SV_FULL)) ? p0_s + 8'd1 : p0_s;
   end

   // Stage 6: reciprocal products for / 15300
   always_comb begin
      qa_in = QT_PRD_W'(qn_ff[5]) * QT_PRD_W'(QT_RECIP);
      ta_in = QT_PRD_W'(tn_ff[5]) * QT_PRD_W'(QT_RECIP);
   end

   // Stage 7: correct q and t, then route per sector; grey when saturation is zero
   always_comb begin
      q0_s   = qa_ff[QT_SHIFT +: CH_W];
      t0_s   = ta_ff[QT_SHIFT +: CH_W];
      qrem_s = qn_ff[6] - 22'(q0_s) * 22'(QT_DEN);
      trem_s = tn_ff[6] - 22'(t0_s) * 22'(QT_DEN);
      q_s    = (qrem_s >= 22'(QT_DEN)) ? q0_s + 8'd1 : q0_s;
      t_s    = (trem_s >= 22'(QT_DEN)) ? t0_s + 8'd1 : t0_s;

      if (sat_ff[6] == '0) begin
         red_in   = val_ff[6];
         green_in = val_ff[6];
         blue_in  = val_ff[6];
      end else begin
         case (sector_ff[6])
            3'd0:    begin red_in = val_ff[6]; green_in = t_s;       blue_in = p_ff[6];   end
            3'd1:    begin red_in = q_s;       green_in = val_ff[6]; blue_in = p_ff[6];   end
            3'd2:    begin red_in = p_ff[6];   green_in = val_ff[6]; blue_in = t_s;       end
            3'd3:    begin red_in = p_ff[6];   green_in = q_s;       blue_in = val_ff[6]; end
            3'd4:    begin red_in = t_s;       green_in = p_ff[6];   blue_in = val_ff[6]; end
            default: begin red_in = val_ff[6]; green_in = p_ff[6];   blue_in = q_s;       end
         endcase
      end
   end

   // Merge both directions; zero the fields of the direction not asked for
   always_comb begin
      res = '0;
      if (act_ff[PIPE_DEPTH]) begin
         res.hue_out = hue_quo;
         res.sat_out = sat_quo[CH_W-1:0];
         res.val_out = mx_ff[PIPE_DEPTH];
      end else begin
         res.red_out   = red_ff;
         res.green_out = green_ff;
         res.blue_out  = blue_ff;
      end
   end

   // Result register plus skid register
   always_comb begin
      out_vld_in    = out_vld_ff;
      skid_vld_in   = skid_vld_ff;
      out_load_res  = 1'b0;
      out_load_skid = 1'b0;
      skid_load     = 1'b0;
      if (rsp_take) begin
         if (skid_vld_ff) begin
            out_load_skid = 1'b1;
            skid_vld_in   = 1'b0;
         end else if (res_arrive) begin
            out_load_res = 1'b1;
         end else begin
            out_vld_in = 1'b0;
         end
      end else if (res_arrive) begin
         if (!out_vld_ff) begin
            out_load_res = 1'b1;
            out_vld_in   = 1'b1;
         end else begin
            skid_load   = 1'b1;
            skid_vld_in = 1'b1;
         end
      end
   end

   // Control: valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (advance) begin
            vld_ff <= {vld_ff[PIPE_DEPTH-1:1], req_accept};
         end
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // Datapath: advance every stage together, hold all of it while frozen
   always_ff @(posedge clock) begin
      if (advance) begin
         act_ff[1] <= pl.action;
         mx_ff[1]  <= mx_in;
         sat_ff[1] <= pl.sat_in;
         val_ff[1] <= pl.val_in;
         for (int i = 2; i <= PIPE_DEPTH; i++) begin
            act_ff[i] <= act_ff[i-1];
            mx_ff[i]  <= mx_ff[i-1];
         end
         for (int i = 2; i <= PIPE_DEPTH - 1; i++) begin
            sat_ff[i] <= sat_ff[i-1];
            val_ff[i] <= val_ff[i-1];
         end

         hprod_ff <= hprod_in;
         hue_ff   <= pl.hue_in;
         delta_ff <= delta_in;
         sel_ff   <= sel_in;
         diff_ff  <= diff_in;

         h_ff     <= h_in;
         div_h_ff <= div_h_in;
         div_s_ff <= div_s_in;

         sector_ff[3] <= sector_in;
         for (int i = 4; i <= PIPE_DEPTH - 1; i++) begin
            sector_ff[i] <= sector_ff[i-1];
         end
         f_ff <= f_in;

         sf_ff <= sf_in;
         sg_ff <= sg_in;
         pn_ff <= pn_in;

         qn_ff[5] <= qn_in;
         tn_ff[5] <= tn_in;
         p_ff[5]  <= p_in;
         qn_ff[6] <= qn_ff[5];
         tn_ff[6] <= tn_ff[5];
         p_ff[6]  <= p_ff[5];

         qa_ff <= qa_in;
         ta_ff <= ta_in;

         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end

      if (out_load_res) begin
         out_ff <= res;
      end else if (out_load_skid) begin
         out_ff <= skid_ff;
      end
      if (skid_load) begin
         skid_ff <= res;
      end
   end

endmodule
